// ----- hdl/kvt_pkg.sv -----
// shared types and command codes for the key/value table engine
package kvt_pkg;

    localparam int CMD_W   = 3;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_UPSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_LOOKUP = 3'd4,
        CMD_READ   = 3'd5
    } kvt_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } kvt_in_t;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   found_key;
        logic [VALUE_W-1:0] found_value;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } kvt_out_t;

    // operation broadcast to every cell of the row
    typedef struct packed {
        logic compare;
        logic insert;
        logic update;
        logic erase;
    } kvt_op_t;

endpackage

// ----- hdl/kvt_cell.sv -----
// one entry cell of the table row: key/value storage, key compare, shift from neighbor
module kvt_cell #(
    parameter int POS         = 0,
    parameter int COUNT_BITS  = 5,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  kvt_pkg::kvt_op_t       op,
    input  logic [COUNT_BITS-1:0]  count,
    input  logic [COUNT_BITS-1:0]  erase_pos,
    input  logic [KEY_WIDTH-1:0]   key_in,
    input  logic [VALUE_WIDTH-1:0] value_in,
    input  logic [KEY_WIDTH-1:0]   next_key,
    input  logic [VALUE_WIDTH-1:0] next_value,
    output logic [KEY_WIDTH-1:0]   key_q,
    output logic [VALUE_WIDTH-1:0] value_q,
    output logic                   hit
);
    import kvt_pkg::*;

    localparam logic [COUNT_BITS-1:0] MY_POS = COUNT_BITS'(POS);

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   hit_reg;
    logic                   in_use;

    assign in_use = MY_POS < count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (op.compare) begin
            hit_reg <= in_use && (key_reg == key_in);
        end
    end

    // payload: insert at the fill point, update on hit, shift down past the erased slot
    always_ff @(posedge aclk) begin
        if (op.insert && (MY_POS == count)) begin
            key_reg   <= key_in;
            value_reg <= value_in;
        end else if (op.update && hit_reg) begin
            value_reg <= value_in;
        end else if (op.erase && (MY_POS >= erase_pos)) begin
            key_reg   <= next_key;
            value_reg <= next_value;
        end
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;
    assign hit     = hit_reg;

endmodule

// ----- hdl/key_value_table_engine.sv -----
// top level of the key/value table engine: command sequencer over a row of entry cells
//
// The table is a packed list of up to DEPTH key/value entries in insertion
// order, held in a row of cells. Each item passes through a compare state
// in which every cell checks its key against the item key at once, and an
// execute state that inserts at the fill point, rewrites the hit value, or
// shifts every later cell down by one on erase. The next item is accepted in
// the execute state of the previous one, so the block can take a new item
// before it is through with the last. A finished result waits in the output
// register; while it waits, the next item may be taken and compared, and it
// stalls in execute until the output register frees. Entry contents are not
// cleared at reset; only the entry count is, so no clearing pass is needed.
// The capacity register limits the table to min(capacity, DEPTH) entries and
// is written through cfg_we.
module key_value_table_engine #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  kvt_pkg::kvt_in_t          s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output kvt_pkg::kvt_out_t         m_item,
    input  logic                      cfg_we,
    input  logic [kvt_pkg::CAP_W-1:0] cfg_wdata
);
    import kvt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int IDX_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } state_t;

    state_t state_reg;

    // latched command
    logic [CMD_W-1:0]       cmd_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [INDEX_W-1:0]     index_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CAP_W-1:0] cap_reg;

    logic     m_valid_reg;
    kvt_out_t m_item_reg;
    kvt_out_t result_next;

    // cell row wiring
    logic [KEY_WIDTH-1:0]   cell_key   [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [KEY_WIDTH-1:0]   nbr_key    [DEPTH];
    logic [VALUE_WIDTH-1:0] nbr_value  [DEPTH];
    logic [DEPTH-1:0]       hit_vec;

    kvt_op_t op;
    logic    out_free;
    logic    go;
    logic    s_fire;

    // reductions over the registered hit vector
    logic                   found;
    logic [CNT_W-1:0]       hit_pos;
    logic [VALUE_WIDTH-1:0] hit_value;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic                   full;
    logic                   idx_ok;
    logic                   do_insert;
    logic                   do_update;
    logic                   do_erase;
    logic                   ok_next;

    assign out_free = !m_valid_reg || m_ready;
    assign go       = (state_reg == ST_EXEC) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || go;
    assign s_fire   = s_valid && s_ready;

    // command latch, payload only
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg   <= s_item.cmd;
            key_reg   <= KEY_WIDTH'(s_item.key);
            value_reg <= VALUE_WIDTH'(s_item.value);
            index_reg <= s_item.index;
        end
    end

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // hit position and hit value: keys are unique, so an or-tree selects
    always_comb begin
        found     = |hit_vec;
        hit_pos   = '0;
        hit_value = '0;
        rd_key    = '0;
        rd_value  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (hit_vec[i]) begin
                hit_pos   = hit_pos | CNT_W'(i);
                hit_value = hit_value | cell_value[i];
            end
            if (IDX_W'(i) == IDX_W'(index_reg)) begin
                rd_key   = cell_key[i];
                rd_value = cell_value[i];
            end
        end
    end

    // table full against min(capacity, DEPTH)
    assign full   = (count_reg >= CNT_W'(DEPTH)) || (LIM_W'(count_reg) >= LIM_W'(cap_reg));
    assign idx_ok = IDX_W'(index_reg) < IDX_W'(count_reg);

    // command decode in the execute cycle
    always_comb begin
        do_insert   = 1'b0;
        do_update   = 1'b0;
        do_erase    = 1'b0;
        ok_next     = 1'b0;
        result_next = '0;
        case (cmd_reg)
            CMD_INSERT: begin
                do_insert = !found && !full;
                ok_next   = do_insert;
            end
            CMD_UPDATE: begin
                do_update = found;
                ok_next   = found;
            end
            CMD_UPSERT: begin
                do_update = found;
                do_insert = !found && !full;
                ok_next   = do_update || do_insert;
            end
            CMD_ERASE: begin
                do_erase = found;
                ok_next  = found;
            end
            CMD_LOOKUP: begin
                ok_next = found;
                if (found) begin
                    result_next.found_value = VALUE_W'(hit_value);
                end
            end
            CMD_READ: begin
                ok_next = idx_ok;
                if (idx_ok) begin
                    result_next.found_key   = KEY_W'(rd_key);
                    result_next.found_value = VALUE_W'(rd_value);
                end
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase

        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_erase) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end

        result_next.ok          = ok_next;
        result_next.entry_count = COUNT_W'(count_next);
        result_next.is_empty    = (count_next == '0);
    end

    // broadcast to the cells; writes only when the execute cycle completes
    always_comb begin
        op.compare = (state_reg == ST_CMP);
        op.insert  = go && do_insert;
        op.update  = go && do_update;
        op.erase   = go && do_erase;
    end

    // sequencer with entry count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (go) begin
                        state_reg <= s_fire ? ST_CMP : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (go) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
                m_item_reg  <= result_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // row of entry cells, each but the last fed by its upper neighbor for the erase shift; the last keeps its own
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_last
            assign nbr_key[i]   = cell_key[i];
            assign nbr_value[i] = cell_value[i];
        end else begin : g_mid
            assign nbr_key[i]   = cell_key[i+1];
            assign nbr_value[i] = cell_value[i+1];
        end

        kvt_cell #(
            .POS         (i),
            .COUNT_BITS  (CNT_W),
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .count      (count_reg),
            .erase_pos  (hit_pos),
            .key_in     (key_reg),
            .value_in   (value_reg),
            .next_key   (nbr_key[i]),
            .next_value (nbr_value[i]),
            .key_q      (cell_key[i]),
            .value_q    (cell_value[i]),
            .hit        (hit_vec[i])
        );
    end

`ifndef NO_ASSERTIONS
    // keys stay unique, so at most one cell hits
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> $onehot0(hit_vec))
        else $error("more than one cell matched the key");

    // a successful insert grows the table by one entry
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && do_insert) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count did not grow on insert");

    // a refused command leaves the entry count alone
    a_refused_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && !ok_next) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed on a refused command");

    // the empty flag tracks the reported count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.is_empty == (m_item.entry_count == '0)))
        else $error("empty flag disagrees with entry count");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the key/value table engine: shadow table predictor, driver and answer monitor
`timescale 1ns / 100ps

module tb_top;
    import kvt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 20;
    localparam int PHASE_ITEMS = 125;
    localparam int CYCLE_LIMIT = 200000;

    // command codes the block does not know; they must leave the table alone
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    // one queued command plus a flag that holds it back until all answers are in
    typedef struct {
        kvt_in_t cmd_item;
        bit      drain;
    } queued_cmd_t;

    // dut ports; the inputs are known from time zero
    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    kvt_in_t          s_item    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    kvt_out_t         m_item;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    // shadow copy of the table and its capacity register
    logic [KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
    logic [VALUE_W-1:0] shadow_vals [TABLE_DEPTH];
    int                 shadow_used = 0;
    logic [CAP_W-1:0]   shadow_cap  = CAP_RESET;

    queued_cmd_t   command_queue [$];
    kvt_out_t      shadow_answers [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          item_taken = 1'b0;

    key_value_table_engine #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // apply one command to the shadow table and return the answer it must give
    function automatic kvt_out_t apply_to_shadow(input kvt_in_t c);
        kvt_out_t r;
        int       slot;
        int       fill_limit;
        r    = '0;
        slot = -1;
        // associative search over the used entries only
        for (int i = 0; i < shadow_used; i++) begin
            if (slot < 0 && shadow_keys[i] == c.key) begin
                slot = i;
            end
        end
        // capacity above the row size saturates
        fill_limit = (shadow_cap > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_cap);
        case (c.cmd)
            CMD_INSERT, CMD_UPDATE, CMD_UPSERT: begin
                if (slot >= 0 && c.cmd != CMD_INSERT) begin
                    // hit: rewrite the value in place
                    shadow_vals[slot] = c.value;
                    r.ok = 1'b1;
                end else if (slot < 0 && c.cmd != CMD_UPDATE && shadow_used < fill_limit) begin
                    // miss with room left: append at the fill point
                    shadow_keys[shadow_used] = c.key;
                    shadow_vals[shadow_used] = c.value;
                    shadow_used++;
                    r.ok = 1'b1;
                end
            end
            CMD_ERASE: begin
                if (slot >= 0) begin
                    // close the gap so the list stays packed
                    for (int i = slot; i < shadow_used - 1; i++) begin
                        shadow_keys[i] = shadow_keys[i + 1];
                        shadow_vals[i] = shadow_vals[i + 1];
                    end
                    shadow_used--;
                    r.ok = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                if (slot >= 0) begin
                    r.found_value = shadow_vals[slot];
                    r.ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (int'(c.index) < shadow_used) begin
                    r.found_key   = shadow_keys[c.index];
                    r.found_value = shadow_vals[c.index];
                    r.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.entry_count = shadow_used[COUNT_W-1:0];
        r.is_empty    = (shadow_used == 0);
        return r;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endfunction

    function automatic void compare_answer(input kvt_out_t want, input kvt_out_t got);
        if (got.ok !== want.ok) begin
            note_mismatch("ok", 32'(want.ok), 32'(got.ok));
        end
        if (got.found_key !== want.found_key) begin
            note_mismatch("found_key", want.found_key, got.found_key);
        end
        if (got.found_value !== want.found_value) begin
            note_mismatch("found_value", want.found_value, got.found_value);
        end
        if (got.entry_count !== want.entry_count) begin
            note_mismatch("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        end
        if (got.is_empty !== want.is_empty) begin
            note_mismatch("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        end
    endfunction

    function automatic void add_cmd(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k,
                                    logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] idx,
                                    bit drain = 1'b0);
        queued_cmd_t q;
        q.cmd_item.cmd   = op;
        q.cmd_item.key   = k;
        q.cmd_item.value = v;
        q.cmd_item.index = idx;
        q.drain          = drain;
        command_queue.push_back(q);
    endfunction

    // mostly pool keys so hits, duplicates and a full table happen often
    function automatic kvt_in_t random_cmd();
        kvt_in_t     it;
        int unsigned pick;
        pick     = $urandom_range(99);
        it.key   = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(POOL_SIZE - 1)];
        it.value = $urandom;
        it.index = INDEX_W'($urandom_range(15));
        if (pick < 28) begin
            it.cmd = CMD_INSERT;
        end else if (pick < 42) begin
            it.cmd = CMD_UPSERT;
        end else if (pick < 52) begin
            it.cmd = CMD_UPDATE;
        end else if (pick < 66) begin
            it.cmd = CMD_ERASE;
        end else if (pick < 80) begin
            it.cmd = CMD_LOOKUP;
        end else if (pick < 96) begin
            it.cmd = CMD_READ;
        end else begin
            it.cmd = ($urandom_range(1) != 0) ? CMD_RSVD7 : CMD_RSVD6;
        end
        return it;
    endfunction

    // block is idle once nothing is queued, presented or outstanding
    task automatic wait_idle();
        while (command_queue.size() != 0 || s_valid || shadow_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(negedge aclk);
        cfg_wdata <= cap;
        cfg_we    <= 1'b1;
        shadow_cap = cap;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // driver: holds an item until taken, then loads the next one or idles
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || item_taken)) begin
            if (command_queue.size() != 0
                && !(command_queue[0].drain && shadow_answers.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
                s_item  <= command_queue[0].cmd_item;
                s_valid <= 1'b1;
                void'(command_queue.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
        // receiver back-pressure
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on every accepted item, check every accepted answer
    always @(posedge aclk) begin
        item_taken = aresetn && s_valid && s_ready;
        if (item_taken) begin
            shadow_answers.push_back(apply_to_shadow(s_item));
        end
        if (aresetn && m_valid && m_ready) begin
            if (shadow_answers.size() == 0) begin
                mismatch_count++;
                $display("%0t: answer with none expected, expected nothing, got %h",
                         $time, m_item);
            end else begin
                compare_answer(shadow_answers.pop_front(), m_item);
            end
        end
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [CAP_W-1:0] phase_caps [6];

        // pool with both extremes and a pair of keys one bit apart
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[3] = key_pool[2] ^ (32'd1 << $urandom_range(31));

        // extremes of the register, one above the row size and one random setting
        phase_caps[0] = 5'd16;
        phase_caps[1] = 5'd3;
        phase_caps[2] = 5'd31;
        phase_caps[3] = 5'd0;
        phase_caps[4] = 5'($urandom_range(15, 1));
        phase_caps[5] = 5'd16;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 68;

        // empty table: every search misses
        add_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 4'd0);
        add_cmd(CMD_READ,   32'h0000_0000, 32'h0000_0000, 4'd0);
        add_cmd(CMD_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
        add_cmd(CMD_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
        // fill, duplicate refused, both upsert paths
        add_cmd(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
        add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 4'd15);
        add_cmd(CMD_INSERT, 32'h0000_0000, 32'h0000_0001, 4'd0);
        add_cmd(CMD_UPSERT, 32'hFFFF_FFFF, 32'h5555_AAAA, 4'd0);
        add_cmd(CMD_UPSERT, 32'h8000_0001, 32'h0000_0001, 4'd0);
        add_cmd(CMD_UPDATE, 32'h0000_0000, 32'hAAAA_5555, 4'd0);
        add_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        // read at the last entry, just past it, and at the top index
        add_cmd(CMD_READ,   32'h0000_0000, 32'h0000_0000, 4'd2);
        add_cmd(CMD_READ,   32'h0000_0000, 32'h0000_0000, 4'd3);
        add_cmd(CMD_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        // unknown codes leave the table alone
        add_cmd(CMD_RSVD6,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        add_cmd(CMD_RSVD7,  32'h0000_0000, 32'h0000_0000, 4'd0);
        // erase at the head shifts the rest down
        add_cmd(CMD_ERASE,  32'h0000_0000, 32'h0000_0000, 4'd0);
        add_cmd(CMD_READ,   32'h0000_0000, 32'h0000_0000, 4'd0);
        add_cmd(CMD_READ,   32'h0000_0000, 32'h0000_0000, 4'd1);
        wait_idle();

        // capacity lowered below the count: entries stay, new keys refused
        write_capacity(5'd1);
        add_cmd(CMD_INSERT, 32'h1234_5678, 32'h0000_0000, 4'd0);
        add_cmd(CMD_UPSERT, 32'h1234_5678, 32'h0000_0000, 4'd0);
        add_cmd(CMD_UPSERT, 32'h8000_0001, 32'hFFFF_FFFF, 4'd0);
        add_cmd(CMD_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
        add_cmd(CMD_INSERT, 32'h1234_5678, 32'h0000_0000, 4'd0);
        add_cmd(CMD_ERASE,  32'h8000_0001, 32'h0000_0000, 4'd0);

        // random phases, one capacity each; idle pattern flips, then goes away
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            if (phase == 2) begin
                send_idle_pct = 68;
                recv_idle_pct = 19;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(phase_caps[phase]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // halfway through, hold the sender until every answer is back
                command_queue.push_back('{random_cmd(), n == PHASE_ITEMS / 2});
            end
        end

        wait_idle();
        // watch for stray answers before closing
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && shadow_answers.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
